// ===== rtl/shaded_ellipse_pixel_generator_core_macros.svh =====
// ----------------------------------------------------------------------------
// shaded ellipse pixel generator assertion macros
// concurrent assertion shorthands shared by the core rtl
// ----------------------------------------------------------------------------
`ifndef SHADED_ELLIPSE_PIXEL_GENERATOR_CORE_MACROS_SVH
`define SHADED_ELLIPSE_PIXEL_GENERATOR_CORE_MACROS_SVH

// same-cycle implication
`define SEG_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SEG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/seg_pkg.sv =====
// ----------------------------------------------------------------------------
// seg_pkg
// shared constants, register indexes and pipeline types of the ellipse core
// ----------------------------------------------------------------------------
package seg_pkg;

   // image bounds, pixels beyond are background
   localparam int unsigned ImageSize  = 256;
   localparam logic [12:0] ImageLimit = 13'(ImageSize);

   // color lanes: 2 red, 1 green, 0 blue
   localparam int ChanCount = 3;
   // quotient bits of the shading divide, one per stage
   localparam int DivSteps  = 8;

   // register indexes
   localparam logic [2:0] CsrCenterX    = 3'd0;
   localparam logic [2:0] CsrCenterY    = 3'd1;
   localparam logic [2:0] CsrRadiusX    = 3'd2;
   localparam logic [2:0] CsrRadiusY    = 3'd3;
   localparam logic [2:0] CsrSkinColor  = 3'd4;
   localparam logic [2:0] CsrBackColor  = 3'd5;
   localparam logic [2:0] CsrShadeFloor = 3'd6;

   // register reset values
   localparam logic [7:0]  CenterXReset    = 8'd128;
   localparam logic [7:0]  CenterYReset    = 8'd128;
   localparam logic [7:0]  RadiusXReset    = 8'd88;
   localparam logic [7:0]  RadiusYReset    = 8'd88;
   localparam logic [23:0] SkinColorReset  = 24'h000000;
   localparam logic [23:0] BackColorReset  = 24'hF5F5F0;
   localparam logic [8:0]  ShadeFloorReset = 9'd166;

   // unity in q1.8
   localparam logic [8:0] ShadeFull = 9'd256;

   // control that travels with each word
   typedef struct packed {
      logic valid;
      logic in_ellipse;
      logic shade;
   } seg_ctl_type;

   // one color lane of the shading divide
   typedef struct packed {
      logic [15:0] rem;
      logic [7:0]  quo;
   } seg_div_type;

   typedef seg_div_type [ChanCount-1:0] seg_lanes_type;

endpackage

// ===== rtl/seg_geom.sv =====
// ----------------------------------------------------------------------------
// seg_geom
// four-stage front end: offsets, squares, ellipse products, inside test and
// the shading numerator of each color lane
// ----------------------------------------------------------------------------
module seg_geom import seg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  logic [7:0]    pixel_x,
   input  logic [7:0]    pixel_y,
   input  logic [7:0]    center_x,
   input  logic [7:0]    center_y,
   input  logic [7:0]    radius_x,
   input  logic [7:0]    radius_y,
   input  logic [23:0]   skin_color,
   input  logic [8:0]    shade_floor,
   output seg_ctl_type   ctl_out,
   output seg_lanes_type lanes_out
);

   // stage 1: absolute offsets and flags
   logic [7:0] s1_adx_in, s1_ady_in;
   logic       s1_ok_in, s1_below_in;
   logic       s1_valid_ff, s1_ok_ff, s1_below_ff;
   logic [7:0] s1_adx_ff, s1_ady_ff;

   // stage 2: squares and shading partial products
   logic [8:0]  shade_sat;
   logic [15:0] s2_adx_sq_in, s2_ady_sq_in, s2_rx_sq_in, s2_ry_sq_in;
   logic [16:0] s2_scale_hi_in, s2_scale_lo_in;
   logic        s2_valid_ff, s2_ok_ff, s2_below_ff;
   logic [15:0] s2_adx_sq_ff, s2_ady_sq_ff, s2_rx_sq_ff, s2_ry_sq_ff;
   logic [16:0] s2_scale_hi_ff, s2_scale_lo_ff;

   // stage 3: ellipse products and shading scale
   logic [31:0] s3_term_x_in, s3_term_y_in, s3_limit_in;
   logic [15:0] s3_scale_in;
   logic        s3_valid_ff, s3_ok_ff, s3_below_ff;
   logic [31:0] s3_term_x_ff, s3_term_y_ff, s3_limit_ff;
   logic [15:0] s3_scale_ff;

   // stage 4: inside test and lane numerators
   logic          s4_in_ellipse_in, s4_shade_in;
   seg_lanes_type s4_lanes_in;
   logic          s4_valid_ff, s4_in_ellipse_ff, s4_shade_ff;
   seg_lanes_type s4_lanes_ff;

   // offsets from the center
   assign s1_adx_in   = (pixel_x >= center_x) ? pixel_x - center_x : center_x - pixel_x;
   assign s1_ady_in   = (pixel_y >= center_y) ? pixel_y - center_y : center_y - pixel_y;
   assign s1_below_in = (pixel_y >= center_y);
   assign s1_ok_in    = ({5'd0, pixel_x} < ImageLimit) && ({5'd0, pixel_y} < ImageLimit)
                        && (radius_x != 8'd0) && (radius_y != 8'd0);

   // shade floor saturates at unity
   assign shade_sat = (shade_floor > ShadeFull) ? ShadeFull : shade_floor;

   // squares
   assign s2_adx_sq_in   = 16'(s1_adx_ff) * 16'(s1_adx_ff);
   assign s2_ady_sq_in   = 16'(s1_ady_ff) * 16'(s1_ady_ff);
   assign s2_rx_sq_in    = 16'(radius_x) * 16'(radius_x);
   assign s2_ry_sq_in    = 16'(radius_y) * 16'(radius_y);
   // floor part and ramp part of the shading scale
   assign s2_scale_hi_in = 17'(shade_sat) * 17'(radius_y);
   assign s2_scale_lo_in = 17'(ShadeFull - shade_sat) * 17'(8'(radius_y - s1_ady_ff));

   // cross products of the ellipse equation
   assign s3_term_x_in = 32'(s2_adx_sq_ff) * 32'(s2_ry_sq_ff);
   assign s3_term_y_in = 32'(s2_ady_sq_ff) * 32'(s2_rx_sq_ff);
   assign s3_limit_in  = 32'(s2_rx_sq_ff) * 32'(s2_ry_sq_ff);
   // never above 256 * ry when used
   assign s3_scale_in  = 16'(s2_scale_hi_ff + s2_scale_lo_ff);

   // inside test, shade only at or below the center row
   assign s4_in_ellipse_in = s3_ok_ff
                             && (({1'b0, s3_term_x_ff} + {1'b0, s3_term_y_ff})
                                 <= {1'b0, s3_limit_ff});
   assign s4_shade_in      = s4_in_ellipse_in && s3_below_ff;

   // numerator of each lane, low byte of the q0.8 product dropped
   always_comb begin
      logic [23:0] prod;
      prod = '0;
      for (int i = 0; i < ChanCount; i++) begin
         prod = 24'(skin_color[8*i +: 8]) * 24'(s3_scale_ff);
         s4_lanes_in[i].rem = prod[23:8];
         s4_lanes_in[i].quo = 8'd0;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_adx_ff        <= s1_adx_in;
         s1_ady_ff        <= s1_ady_in;
         s1_ok_ff         <= s1_ok_in;
         s1_below_ff      <= s1_below_in;
         s2_adx_sq_ff     <= s2_adx_sq_in;
         s2_ady_sq_ff     <= s2_ady_sq_in;
         s2_rx_sq_ff      <= s2_rx_sq_in;
         s2_ry_sq_ff      <= s2_ry_sq_in;
         s2_scale_hi_ff   <= s2_scale_hi_in;
         s2_scale_lo_ff   <= s2_scale_lo_in;
         s2_ok_ff         <= s1_ok_ff;
         s2_below_ff      <= s1_below_ff;
         s3_term_x_ff     <= s3_term_x_in;
         s3_term_y_ff     <= s3_term_y_in;
         s3_limit_ff      <= s3_limit_in;
         s3_scale_ff      <= s3_scale_in;
         s3_ok_ff         <= s2_ok_ff;
         s3_below_ff      <= s2_below_ff;
         s4_in_ellipse_ff <= s4_in_ellipse_in;
         s4_shade_ff      <= s4_shade_in;
         s4_lanes_ff      <= s4_lanes_in;
      end
   end

   assign ctl_out   = '{valid: s4_valid_ff, in_ellipse: s4_in_ellipse_ff, shade: s4_shade_ff};
   assign lanes_out = s4_lanes_ff;

endmodule

// ===== rtl/seg_div_stage.sv =====
// ----------------------------------------------------------------------------
// seg_div_stage
// one restoring-division step on all color lanes: one quotient bit per stage
// ----------------------------------------------------------------------------
module seg_div_stage import seg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic [7:0]    radius_y,
   input  seg_ctl_type   ctl_in,
   input  seg_lanes_type lanes_in,
   output seg_ctl_type   ctl_out,
   output seg_lanes_type lanes_out
);

   logic [15:0]   divisor;
   seg_lanes_type lanes_in_next;
   logic          valid_ff;
   logic          in_ellipse_ff, shade_ff;
   seg_lanes_type lanes_ff;

   // divisor aligned with the top quotient bit
   assign divisor = {1'b0, radius_y, 7'd0};

   // compare, subtract, shift the remainder up
   always_comb begin
      logic        take;
      logic [15:0] diff;
      take = 1'b0;
      diff = '0;
      for (int i = 0; i < ChanCount; i++) begin
         take = (lanes_in[i].rem >= divisor);
         diff = take ? lanes_in[i].rem - divisor : lanes_in[i].rem;
         lanes_in_next[i].rem = {diff[14:0], 1'b0};
         lanes_in_next[i].quo = {lanes_in[i].quo[6:0], take};
      end
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= ctl_in.valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (advance) begin
         in_ellipse_ff <= ctl_in.in_ellipse;
         shade_ff      <= ctl_in.shade;
         lanes_ff      <= lanes_in_next;
      end
   end

   assign ctl_out   = '{valid: valid_ff, in_ellipse: in_ellipse_ff, shade: shade_ff};
   assign lanes_out = lanes_ff;

endmodule

// ===== rtl/shaded_ellipse_pixel_generator_core.sv =====
// ----------------------------------------------------------------------------
// shaded ellipse pixel generator core
// colors one pixel per word: background, or skin shaded toward the bottom
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries a pixel coordinate (req_pixel_x, req_pixel_y) under
//   valid/ready. rsp channel returns one word per pixel: rsp_red, rsp_green,
//   rsp_blue and rsp_inside_res, in the order the pixels were taken.
//   csr port writes the ellipse registers at any edge with csr_write_en high;
//   write only while no pixel is in flight.
//   Path: a pixel taken on req passes the 4 geometry stages, 8 divide stages
//   and the output register before it shows on rsp.
//   Throughput: one pixel per clock when not stalled; each divide stage yields
//   one quotient bit for all three lanes, and the pipeline is 13 registers deep.
//   Stall: with rsp_ready low and a word waiting, the whole pipeline holds
//   and req_ready falls; nothing is dropped or repeated.
//   Reset: synchronous, clears all valid bits and loads the register
//   defaults (center 128/128, radii 88/88, shade floor 166).
// ----------------------------------------------------------------------------
`include "shaded_ellipse_pixel_generator_core_macros.svh"

module shaded_ellipse_pixel_generator_core import seg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // pixel request
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_pixel_x,
   input  logic [7:0]  req_pixel_y,
   // color response
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_inside_res,
   // register writes
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   logic [7:0]  center_x_ff, center_y_ff, radius_x_ff, radius_y_ff;
   logic [23:0] skin_color_ff, back_color_ff;
   logic [8:0]  shade_floor_ff;

   logic          advance;
   seg_ctl_type   div_ctl   [0:DivSteps];
   seg_lanes_type div_lanes [0:DivSteps];

   logic [23:0] color_in;
   logic        rsp_valid_ff;
   logic [23:0] color_ff;
   logic        in_ellipse_ff;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= CenterXReset;
         center_y_ff    <= CenterYReset;
         radius_x_ff    <= RadiusXReset;
         radius_y_ff    <= RadiusYReset;
         skin_color_ff  <= SkinColorReset;
         back_color_ff  <= BackColorReset;
         shade_floor_ff <= ShadeFloorReset;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CsrCenterX:    center_x_ff    <= csr_data[7:0];
            CsrCenterY:    center_y_ff    <= csr_data[7:0];
            CsrRadiusX:    radius_x_ff    <= csr_data[7:0];
            CsrRadiusY:    radius_y_ff    <= csr_data[7:0];
            CsrSkinColor:  skin_color_ff  <= csr_data;
            CsrBackColor:  back_color_ff  <= csr_data;
            CsrShadeFloor: shade_floor_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   // whole pipeline moves when the output register is free or drains
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // geometry front end
   seg_geom u_geom (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_valid),
      .pixel_x     (req_pixel_x),
      .pixel_y     (req_pixel_y),
      .center_x    (center_x_ff),
      .center_y    (center_y_ff),
      .radius_x    (radius_x_ff),
      .radius_y    (radius_y_ff),
      .skin_color  (skin_color_ff),
      .shade_floor (shade_floor_ff),
      .ctl_out     (div_ctl[0]),
      .lanes_out   (div_lanes[0])
   );

   // shading divide, msb first
   for (genvar g = 0; g < DivSteps; g++) begin : g_div
      seg_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .radius_y  (radius_y_ff),
         .ctl_in    (div_ctl[g]),
         .lanes_in  (div_lanes[g]),
         .ctl_out   (div_ctl[g+1]),
         .lanes_out (div_lanes[g+1])
      );
   end

   // final color pick per lane
   always_comb begin
      for (int i = 0; i < ChanCount; i++) begin
         priority if (!div_ctl[DivSteps].in_ellipse) begin
            color_in[8*i +: 8] = back_color_ff[8*i +: 8];
         end else if (div_ctl[DivSteps].shade) begin
            color_in[8*i +: 8] = div_lanes[DivSteps][i].quo;
         end else begin
            color_in[8*i +: 8] = skin_color_ff[8*i +: 8];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_ctl[DivSteps].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         color_ff      <= color_in;
         in_ellipse_ff <= div_ctl[DivSteps].in_ellipse;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red        = color_ff[23:16];
   assign rsp_green      = color_ff[15:8];
   assign rsp_blue       = color_ff[7:0];
   assign rsp_inside_res = in_ellipse_ff;

   // checks
   `SEG_ASSERT_IMPLIES(a_shade_inside, clock, reset, div_ctl[DivSteps].valid && div_ctl[DivSteps].shade, div_ctl[DivSteps].in_ellipse, "shaded word lies outside the ellipse")
   `SEG_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid_ff && !div_ctl[0].valid && !div_ctl[DivSteps].valid, "pipeline holds a word after reset")
   `SEG_ASSERT_NEXT(a_stall_hold, clock, reset, !advance, $stable(div_ctl[DivSteps]) && $stable(div_lanes[DivSteps]), "divide output moved during a stall")

endmodule
